### rtl/mrm_pkg.sv
// Shared constants and codes for the modem response matcher.
`timescale 1ns / 1ps

package mrm_pkg;

    // Pattern size limits.
    localparam int MAX_EXPECTED = 16;
    localparam int MAX_SERVER   = 7;

    // Field and register widths.
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int EXP_LEN_W  = $clog2(MAX_EXPECTED + 1);
    localparam int EXP_IDX_W  = (MAX_EXPECTED > 1) ? $clog2(MAX_EXPECTED) : 1;
    localparam int SRV_LEN_W  = $clog2(MAX_SERVER + 1);
    localparam int SRV_IDX_W  = (MAX_SERVER > 1) ? $clog2(MAX_SERVER) : 1;
    localparam int TICK_W     = 16;

    // Input transaction modes.
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ERRCLOSE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRV      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRV_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd5;

endpackage

### rtl/modem_response_matcher.sv
// Modem reply matcher: four parallel byte matchers and an idle tick timeout.
`timescale 1ns / 1ps
// A transaction accepted into the input register has its status written into the
// result register when it is processed. Throughput: one transaction per cycle
// unless a held result stalls it; the matcher state is one register set updated by
// single-level compare logic between the input and result registers.
// Reset (aresetn low, synchronous): configuration registers, matcher indexes, the
// idle counter, the waiting flag and both valid flags clear; the block is idle.

module modem_response_matcher import mrm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [BYTE_W-1:0]     s_rx_byte,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status
);

    localparam int SRV_BYTES_W = MAX_SERVER * BYTE_W;
    localparam int EXP_BYTES_W = MAX_EXPECTED * BYTE_W;

    localparam logic [BYTE_W-1:0] ERR_TEXT [0:6] =
        '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};
    localparam logic [BYTE_W-1:0] CLS_TEXT [0:7] =
        '{8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h44, 8'h0D, 8'h0A};

    // Configuration registers.
    logic [63:0]          exp_low_reg;
    logic [63:0]          exp_high_reg;
    logic [4:0]           exp_len_reg;
    logic [55:0]          srv_bytes_reg;
    logic [2:0]           srv_len_reg;
    logic [TICK_W-1:0]    timeout_reg;

    // Matcher state.
    logic [EXP_IDX_W-1:0] exp_idx_reg, exp_idx_next;
    logic [2:0]           err_idx_reg, err_idx_next;
    logic [2:0]           cls_idx_reg, cls_idx_next;
    logic [SRV_IDX_W-1:0] srv_idx_reg, srv_idx_next;
    logic [TICK_W-1:0]    idle_reg, idle_next;
    logic                 waiting_reg, waiting_next;

    // Input and result registers.
    logic                 in_valid_reg;
    logic [MODE_W-1:0]    in_mode_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [STATUS_W-1:0]  status_next;

    logic                 process;
    logic [EXP_LEN_W-1:0] elen;
    logic [SRV_LEN_W-1:0] slen;
    logic [EXP_BYTES_W-1:0] exp_word;
    logic [63:0]          srv_word;
    logic [BYTE_W-1:0]    epat, spat, rb;
    logic                 nz;
    logic                 exp_hit, exp_done;
    logic                 err_hit, err_done;
    logic                 cls_hit, cls_done;
    logic                 srv_hit, srv_done;
    logic [TICK_W-1:0]    idle_inc;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_low_reg   <= '0;
            exp_high_reg  <= '0;
            exp_len_reg   <= '0;
            srv_bytes_reg <= '0;
            srv_len_reg   <= '0;
            timeout_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EXP_LOW:  exp_low_reg   <= cfg_wr_data;
                REG_EXP_HIGH: exp_high_reg  <= cfg_wr_data;
                REG_EXP_LEN:  exp_len_reg   <= cfg_wr_data[4:0];
                REG_SRV:      srv_bytes_reg <= cfg_wr_data[55:0];
                REG_SRV_LEN:  srv_len_reg   <= cfg_wr_data[2:0];
                REG_TIMEOUT:  timeout_reg   <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a transaction moves on whenever the result register is empty or being read.
    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign m_valid = out_valid_reg;
    assign m_status = out_status_reg;

    // Pattern lengths clamped to the matcher sizes.
    assign elen = (exp_len_reg > 5'(MAX_EXPECTED)) ? EXP_LEN_W'(MAX_EXPECTED)
                                                  : EXP_LEN_W'(exp_len_reg);
    assign slen = (srv_len_reg > 3'(MAX_SERVER)) ? SRV_LEN_W'(MAX_SERVER)
                                                : SRV_LEN_W'(srv_len_reg);

    // Current pattern bytes for each matcher.
    assign exp_word = EXP_BYTES_W'({exp_high_reg, exp_low_reg});
    assign srv_word = 64'(srv_bytes_reg[SRV_BYTES_W-1:0]);
    assign epat = exp_word[exp_idx_reg*BYTE_W +: BYTE_W];
    assign spat = srv_word[srv_idx_reg*BYTE_W +: BYTE_W];
    assign rb = in_byte_reg;
    assign nz = (rb != '0);

    // Per-matcher compare and completion; a zero byte never matches.
    assign exp_hit  = (elen != '0) && ((EXP_LEN_W+1)'(exp_idx_reg) < (EXP_LEN_W+1)'(elen))
                      && nz && (rb == epat);
    assign exp_done = exp_hit && ((EXP_LEN_W+1)'(exp_idx_reg) + 1'b1 >= (EXP_LEN_W+1)'(elen));
    assign err_hit  = (err_idx_reg < 3'd7) && nz && (rb == ERR_TEXT[err_idx_reg]);
    assign err_done = err_hit && (err_idx_reg == 3'd6);
    assign cls_hit  = nz && (rb == CLS_TEXT[cls_idx_reg]);
    assign cls_done = cls_hit && (cls_idx_reg == 3'd7);
    assign srv_hit  = (slen != '0) && ((SRV_LEN_W+1)'(srv_idx_reg) < (SRV_LEN_W+1)'(slen))
                      && nz && (rb == spat);
    assign srv_done = srv_hit && ((SRV_LEN_W+1)'(srv_idx_reg) + 1'b1 >= (SRV_LEN_W+1)'(slen));

    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    // Next matcher state and status for the transaction in the input register.
    always_comb begin
        exp_idx_next = exp_idx_reg;
        err_idx_next = err_idx_reg;
        cls_idx_next = cls_idx_reg;
        srv_idx_next = srv_idx_reg;
        idle_next    = idle_reg;
        waiting_next = waiting_reg;
        status_next  = ST_WAIT;
        if (in_mode_reg == MODE_START) begin
            exp_idx_next = '0;
            err_idx_next = '0;
            cls_idx_next = '0;
            srv_idx_next = '0;
            idle_next    = '0;
            if (timeout_reg == '0) begin
                waiting_next = 1'b0;
                status_next  = ST_TIMEOUT;
            end else begin
                waiting_next = 1'b1;
            end
        end else if (!waiting_reg) begin
            status_next = ST_IDLE;
        end else if (in_mode_reg == MODE_BYTE) begin
            priority if (exp_done) begin
                status_next = ST_EXPECTED;
            end else if (err_done || cls_done) begin
                status_next = ST_ERRCLOSE;
            end else if (srv_done) begin
                status_next = ST_SERVER;
            end else if (elen == '0) begin
                status_next = ST_EXPECTED;
            end else begin
                status_next = ST_WAIT;
            end
            idle_next = '0;
            if (status_next == ST_WAIT) begin
                exp_idx_next = exp_hit ? exp_idx_reg + 1'b1 : '0;
                err_idx_next = err_hit ? err_idx_reg + 1'b1 : '0;
                cls_idx_next = cls_hit ? cls_idx_reg + 1'b1 : '0;
                srv_idx_next = srv_hit ? srv_idx_reg + 1'b1 : '0;
            end else begin
                exp_idx_next = '0;
                err_idx_next = '0;
                cls_idx_next = '0;
                srv_idx_next = '0;
                waiting_next = 1'b0;
            end
        end else if (in_mode_reg == MODE_TICK) begin
            if (idle_inc >= timeout_reg) begin
                exp_idx_next = '0;
                err_idx_next = '0;
                cls_idx_next = '0;
                srv_idx_next = '0;
                idle_next    = '0;
                waiting_next = 1'b0;
                status_next  = ST_TIMEOUT;
            end else begin
                idle_next = idle_inc;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            exp_idx_reg   <= '0;
            err_idx_reg   <= '0;
            cls_idx_reg   <= '0;
            srv_idx_reg   <= '0;
            idle_reg      <= '0;
            waiting_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
                exp_idx_reg   <= exp_idx_next;
                err_idx_reg   <= err_idx_next;
                cls_idx_reg   <= cls_idx_next;
                srv_idx_reg   <= srv_idx_next;
                idle_reg      <= idle_next;
                waiting_reg   <= waiting_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_rx_byte;
        end
        if (process) begin
            out_status_reg <= status_next;
        end
    end

    // Outside a wait every matcher index and the idle counter sit at zero.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !waiting_reg |-> (exp_idx_reg == '0) && (err_idx_reg == '0) &&
                         (cls_idx_reg == '0) && (srv_idx_reg == '0) && (idle_reg == '0))
        else $error("matcher state not cleared outside a wait");

    // Error-text and server indexes stay inside their patterns.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_idx_reg < 3'd7) && ((SRV_IDX_W+1)'(srv_idx_reg) < (SRV_IDX_W+1)'(MAX_SERVER)))
        else $error("matcher index beyond pattern");

    // A start transaction reports either waiting or an immediate timeout.
    a_start_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && (in_mode_reg == MODE_START)) |=>
            m_valid && ((m_status == ST_WAIT) || (m_status == ST_TIMEOUT)))
        else $error("bad status after start");

    // A full pipeline behind a stalled result takes no new transaction.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg) |-> !s_ready)
        else $error("input taken while pipeline is full");

    // A processed transaction always leaves a result behind.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_valid_reg)
        else $error("processed transaction produced no result");

endmodule
